@@ hw/rtl/mlca_pkg.sv @@
// shared types and constants for the meter line check and average unit
package mlca_pkg;

  // accumulator and result widths
  localparam int unsigned ACC_W = 40;
  localparam int unsigned CNT_W = 6;
  localparam int unsigned AVG_W = 32;

  // line layout constants
  localparam logic [2:0]  LABEL_LEN     = 3'd4;
  localparam logic [2:0]  LABEL_LEN_MAX = 3'd5;
  localparam logic [5:0]  CHECK_SEED    = 6'd32;
  localparam logic [7:0]  CHECK_OFFSET  = 8'd32;
  localparam logic [31:0] MAG_LIMIT     = 32'h8000_0000;
  localparam logic [31:0] POS_LIMIT     = 32'h7fff_ffff;

  // characters of interest
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0d;
  localparam logic [7:0] CHAR_PLUS  = 8'h2b;
  localparam logic [7:0] CHAR_MINUS = 8'h2d;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  // the two labels that feed the averages
  localparam logic [7:0] WORD_PAPP [4] = '{8'h50, 8'h41, 8'h50, 8'h50};
  localparam logic [7:0] WORD_BASE [4] = '{8'h42, 8'h41, 8'h53, 8'h45};

  // line status codes
  typedef enum logic [1:0] {
    STATUS_OK           = 2'd0,
    STATUS_NO_VALUE_SEP = 2'd1,
    STATUS_NO_CHECK_SEP = 2'd2,
    STATUS_BAD_CHECK    = 2'd3
  } mlca_status_e;

  // position within the line
  typedef enum logic [3:0] {
    PH_LABEL = 4'b0001,
    PH_VALUE = 4'b0010,
    PH_CHECK = 4'b0100,
    PH_DONE  = 4'b1000
  } mlca_phase_e;

  // input transaction
  typedef struct packed {
    logic [7:0] line_byte;
    logic       end_of_line;
  } mlca_in_t;

  // output transaction
  typedef struct packed {
    logic [1:0]              status;
    logic                    average_valid;
    logic                    average_kind;
    logic signed [AVG_W-1:0] average_value;
  } mlca_out_t;

  // finished line handed from the parser to the average pipeline
  typedef struct packed {
    mlca_status_e     status;
    logic             avg_valid;
    logic             avg_kind;
    logic [ACC_W-1:0] sum;
  } mlca_line_t;

endpackage

@@ hw/rtl/mlca_avg_pipe.sv @@
// report pipeline: signed average by constant reciprocal multiply, with output register
module mlca_avg_pipe #(
  parameter int unsigned SAMPLES_PER_AVERAGE = 60
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               line_valid_i,
  output logic               line_ready_o,
  input  mlca_pkg::mlca_line_t line_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output mlca_pkg::mlca_out_t  out_data_o
);
  import mlca_pkg::*;

  localparam int unsigned NSTAGE = 7;

  // exact floor division by a constant through a rounded-up reciprocal
  localparam int unsigned DIV_P   = SAMPLES_PER_AVERAGE;
  localparam int unsigned DIV_B   = 1000 * SAMPLES_PER_AVERAGE;
  localparam int unsigned SHIFT_P = ACC_W + $clog2(DIV_P);
  localparam int unsigned SHIFT_B = ACC_W + $clog2(DIV_B);
  localparam int unsigned MUL_W   = ACC_W + 1;
  localparam logic [63:0] MUL_P_FULL =
      ((64'd1 << SHIFT_P) + 64'(DIV_P) - 64'd1) / 64'(DIV_P);
  localparam logic [63:0] MUL_B_FULL =
      ((64'd1 << SHIFT_B) + 64'(DIV_B) - 64'd1) / 64'(DIV_B);
  localparam logic [MUL_W-1:0] MUL_P = MUL_P_FULL[MUL_W-1:0];
  localparam logic [MUL_W-1:0] MUL_B = MUL_B_FULL[MUL_W-1:0];

  // partial product split
  localparam int unsigned XL_W   = ACC_W / 2;
  localparam int unsigned XH_W   = ACC_W - XL_W;
  localparam int unsigned ML_W   = (MUL_W + 1) / 2;
  localparam int unsigned MH_W   = MUL_W - ML_W;
  localparam int unsigned PLL_W  = XL_W + ML_W;
  localparam int unsigned PLH_W  = XL_W + MH_W;
  localparam int unsigned PHL_W  = XH_W + ML_W;
  localparam int unsigned PHH_W  = XH_W + MH_W;
  localparam int unsigned LOW_W  = XL_W + MUL_W + 1;
  localparam int unsigned HIGH_W = XH_W + MUL_W + 1;
  localparam int unsigned FULL_W = ACC_W + MUL_W + 1;

  // side information that rides along the stages
  typedef struct packed {
    mlca_status_e status;
    logic         avg_valid;
    logic         avg_kind;
    logic         neg;
  } tag_t;

  logic [NSTAGE-1:0] valid_q;
  logic [NSTAGE:0]   load;

  mlca_line_t        line_q;
  tag_t              tag1_q, tag2_q, tag3_q, tag4_q, tag5_q;
  logic [ACC_W-1:0]  mag1_q;
  logic [XH_W-1:0]   xh2_q;
  logic [PLL_W-1:0]  pll2_q;
  logic [PLH_W-1:0]  plh2_q;
  logic [PHL_W-1:0]  phl3_q;
  logic [PHH_W-1:0]  phh3_q;
  logic [LOW_W-1:0]  low3_q, low4_q;
  logic [HIGH_W-1:0] high4_q;
  logic [ACC_W-1:0]  quot5_q;
  mlca_out_t         out_q;

  tag_t              tag1_d;
  logic [ACC_W-1:0]  mag1_d;
  logic [ML_W-1:0]   ml1, ml2;
  logic [MH_W-1:0]   mh1, mh2;
  logic [FULL_W-1:0] full4;
  logic [FULL_W-1:0] shifted4;
  logic [ACC_W-1:0]  signed5;
  mlca_out_t         out_d;

  // stage advance: a stage loads when empty or when its content moves on
  assign load[NSTAGE] = !out_stall_i;
  for (genvar g = 0; g < NSTAGE; g++) begin : g_load
    assign load[g] = !valid_q[g] || load[g+1];
  end
  assign line_ready_o = load[0];

  // stage valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (load[0]) begin
        valid_q[0] <= line_valid_i;
      end
      for (int unsigned i = 1; i < NSTAGE; i++) begin
        if (load[i]) begin
          valid_q[i] <= valid_q[i-1];
        end
      end
    end
  end

  // magnitude and sign of the accumulated sum
  always_comb begin
    tag1_d.status    = line_q.status;
    tag1_d.avg_valid = line_q.avg_valid;
    tag1_d.avg_kind  = line_q.avg_kind;
    tag1_d.neg       = line_q.sum[ACC_W-1];
    mag1_d = line_q.sum[ACC_W-1] ? (~line_q.sum + ACC_W'(1)) : line_q.sum;
  end

  // reciprocal halves for the two kinds
  assign ml1 = tag1_q.avg_kind ? MUL_B[ML_W-1:0] : MUL_P[ML_W-1:0];
  assign mh1 = tag1_q.avg_kind ? MUL_B[MUL_W-1:ML_W] : MUL_P[MUL_W-1:ML_W];
  assign ml2 = tag2_q.avg_kind ? MUL_B[ML_W-1:0] : MUL_P[ML_W-1:0];
  assign mh2 = tag2_q.avg_kind ? MUL_B[MUL_W-1:ML_W] : MUL_P[MUL_W-1:ML_W];

  // recombine and drop the fraction
  assign full4    = FULL_W'(low4_q) + (FULL_W'(high4_q) << XL_W);
  assign shifted4 = tag4_q.avg_kind ? (full4 >> SHIFT_B) : (full4 >> SHIFT_P);

  // restore the sign, zero the fields when no average is reported
  always_comb begin
    signed5 = tag5_q.neg ? (~quot5_q + ACC_W'(1)) : quot5_q;
    out_d.status        = tag5_q.status;
    out_d.average_valid = tag5_q.avg_valid;
    out_d.average_kind  = tag5_q.avg_valid & tag5_q.avg_kind;
    out_d.average_value = tag5_q.avg_valid ? signed'(signed5[AVG_W-1:0]) : '0;
  end

  // stage payload registers
  always_ff @(posedge clk_i) begin
    if (load[0]) begin
      line_q <= line_i;
    end
    if (load[1]) begin
      tag1_q <= tag1_d;
      mag1_q <= mag1_d;
    end
    if (load[2]) begin
      tag2_q <= tag1_q;
      xh2_q  <= mag1_q[ACC_W-1:XL_W];
      pll2_q <= PLL_W'(mag1_q[XL_W-1:0]) * PLL_W'(ml1);
      plh2_q <= PLH_W'(mag1_q[XL_W-1:0]) * PLH_W'(mh1);
    end
    if (load[3]) begin
      tag3_q <= tag2_q;
      phl3_q <= PHL_W'(xh2_q) * PHL_W'(ml2);
      phh3_q <= PHH_W'(xh2_q) * PHH_W'(mh2);
      low3_q <= LOW_W'(pll2_q) + (LOW_W'(plh2_q) << ML_W);
    end
    if (load[4]) begin
      tag4_q  <= tag3_q;
      high4_q <= HIGH_W'(phl3_q) + (HIGH_W'(phh3_q) << ML_W);
      low4_q  <= low3_q;
    end
    if (load[5]) begin
      tag5_q  <= tag4_q;
      quot5_q <= shifted4[ACC_W-1:0];
    end
    if (load[6]) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = valid_q[NSTAGE-1];
  assign out_data_o  = out_q;

endmodule

@@ hw/rtl/meter_line_check_and_average_unit.sv @@
// Meter line checker and averager. Takes one byte of a "LABEL VALUE C" line per
// cycle while the input is not stalled, keeps the running 6-bit check sum and an
// atoi-style value, and on the byte marked end_of_line reports a status; accepted
// PAPP and BASE lines feed 40-bit accumulators and every SAMPLES_PER_AVERAGE
// samples of a kind the report carries the truncated average (BASE in kWh).
// The report for a line leaves through the output register of a seven-stage
// reciprocal-multiply pipeline that holds up to seven pending reports. Input
// stalls only while that pipeline is full and the output transaction is held.
module meter_line_check_and_average_unit #(
  parameter int unsigned SAMPLES_PER_AVERAGE = 60
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  mlca_pkg::mlca_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output mlca_pkg::mlca_out_t out_data_o
);
  import mlca_pkg::*;

  localparam logic [CNT_W-1:0] SAMPLES = CNT_W'(SAMPLES_PER_AVERAGE);

  logic              pipe_ready;
  logic              in_acc;
  logic              line_valid;
  mlca_line_t        line_d;

  mlca_phase_e       phase_q, phase_d;
  logic [5:0]        check_q, check_d;
  logic [2:0]        label_len_q, label_len_d;
  logic [1:0]        match_q, match_d;
  logic [31:0]       value_q, value_d;
  logic              neg_q, neg_d;
  logic              started_q, started_d;
  logic              stopped_q, stopped_d;
  logic [7:0]        rx_check_q, rx_check_d;
  logic [ACC_W-1:0]  psum_q, psum_d;
  logic [CNT_W-1:0]  pcnt_q, pcnt_d;
  logic [ACC_W-1:0]  esum_q, esum_d;
  logic [CNT_W-1:0]  ecnt_q, ecnt_d;

  logic [7:0]        b;
  logic              is_digit;
  logic [35:0]       times10;
  logic [31:0]       value_sat;
  logic [ACC_W-1:0]  parsed;
  logic [ACC_W-1:0]  psum_new, esum_new;
  logic [CNT_W-1:0]  pcnt_new, ecnt_new;
  mlca_status_e      status;
  logic              sample_hit;

  assign in_stall_o = !pipe_ready;
  assign in_acc     = in_valid_i && pipe_ready;
  assign line_valid = in_acc && in_data_i.end_of_line;

  // digit accumulation with saturation at 2^31
  assign b        = in_data_i.line_byte;
  assign is_digit = b inside {[CHAR_ZERO:CHAR_NINE]};
  assign times10  = (36'(value_q) << 3) + (36'(value_q) << 1) + 36'(b[3:0]);
  assign value_sat = (times10 > 36'(MAG_LIMIT)) ? MAG_LIMIT : times10[31:0];

  // signed value of the parsed field
  always_comb begin
    if (neg_q) begin
      parsed = ~ACC_W'(value_q) + ACC_W'(1);
    end else if (value_q > POS_LIMIT) begin
      parsed = ACC_W'(POS_LIMIT);
    end else begin
      parsed = ACC_W'(value_q);
    end
  end

  assign psum_new = psum_q + parsed;
  assign esum_new = esum_q + parsed;
  assign pcnt_new = pcnt_q + CNT_W'(1);
  assign ecnt_new = ecnt_q + CNT_W'(1);

  // byte parser and line end handling
  always_comb begin
    phase_d     = phase_q;
    check_d     = check_q;
    label_len_d = label_len_q;
    match_d     = match_q;
    value_d     = value_q;
    neg_d       = neg_q;
    started_d   = started_q;
    stopped_d   = stopped_q;
    rx_check_d  = rx_check_q;
    psum_d      = psum_q;
    pcnt_d      = pcnt_q;
    esum_d      = esum_q;
    ecnt_d      = ecnt_q;
    status      = STATUS_OK;
    sample_hit  = 1'b0;
    line_d.status    = STATUS_OK;
    line_d.avg_valid = 1'b0;
    line_d.avg_kind  = 1'b0;
    line_d.sum       = psum_new;

    if (in_acc) begin
      case (phase_q)
        PH_LABEL: begin
          if (b == CHAR_SPACE) begin
            phase_d = PH_VALUE;
          end else begin
            check_d = check_q + b[5:0];
            if (label_len_q < LABEL_LEN) begin
              if (b != WORD_PAPP[label_len_q[1:0]]) begin
                match_d[0] = 1'b0;
              end
              if (b != WORD_BASE[label_len_q[1:0]]) begin
                match_d[1] = 1'b0;
              end
            end else begin
              match_d = 2'b00;
            end
            if (label_len_q < LABEL_LEN_MAX) begin
              label_len_d = label_len_q + 3'd1;
            end
          end
        end
        PH_VALUE: begin
          if (b == CHAR_SPACE) begin
            phase_d = PH_CHECK;
          end else begin
            check_d = check_q + b[5:0];
            if (!stopped_q) begin
              if (!started_q && (b inside {[CHAR_TAB:CHAR_CR]})) begin
                started_d = 1'b0;
              end else if (!started_q && (b == CHAR_PLUS || b == CHAR_MINUS)) begin
                started_d = 1'b1;
                neg_d     = (b == CHAR_MINUS);
              end else if (is_digit) begin
                value_d   = value_sat;
                started_d = 1'b1;
              end else begin
                stopped_d = 1'b1;
              end
            end
          end
        end
        PH_CHECK: begin
          rx_check_d = b;
          phase_d    = PH_DONE;
        end
        default: begin
          phase_d = phase_q;
        end
      endcase

      if (in_data_i.end_of_line) begin
        // status from where the line stopped
        case (phase_d)
          PH_LABEL: status = STATUS_NO_VALUE_SEP;
          PH_VALUE: status = STATUS_NO_CHECK_SEP;
          PH_DONE: begin
            status = (rx_check_d == ({2'b00, check_d} + CHECK_OFFSET)) ?
                     STATUS_OK : STATUS_BAD_CHECK;
          end
          default:  status = STATUS_BAD_CHECK;
        endcase
        sample_hit = (status == STATUS_OK) && (label_len_q == LABEL_LEN) &&
                     (match_q != 2'b00);

        // accumulate an accepted sample, close the average on the last one
        if (sample_hit) begin
          if (match_q[0]) begin
            line_d.sum = psum_new;
            if (pcnt_new == SAMPLES) begin
              line_d.avg_valid = 1'b1;
              psum_d = '0;
              pcnt_d = '0;
            end else begin
              psum_d = psum_new;
              pcnt_d = pcnt_new;
            end
          end else begin
            line_d.sum      = esum_new;
            line_d.avg_kind = 1'b1;
            if (ecnt_new == SAMPLES) begin
              line_d.avg_valid = 1'b1;
              esum_d = '0;
              ecnt_d = '0;
            end else begin
              esum_d = esum_new;
              ecnt_d = ecnt_new;
            end
          end
        end
        line_d.status = status;

        // back to the start of a line
        phase_d     = PH_LABEL;
        check_d     = CHECK_SEED;
        label_len_d = 3'd0;
        match_d     = 2'b11;
        value_d     = '0;
        neg_d       = 1'b0;
        started_d   = 1'b0;
        stopped_d   = 1'b0;
        rx_check_d  = '0;
      end
    end
  end

  // parser and accumulator state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_LABEL;
      check_q     <= CHECK_SEED;
      label_len_q <= 3'd0;
      match_q     <= 2'b11;
      value_q     <= '0;
      neg_q       <= 1'b0;
      started_q   <= 1'b0;
      stopped_q   <= 1'b0;
      rx_check_q  <= '0;
      psum_q      <= '0;
      pcnt_q      <= '0;
      esum_q      <= '0;
      ecnt_q      <= '0;
    end else begin
      phase_q     <= phase_d;
      check_q     <= check_d;
      label_len_q <= label_len_d;
      match_q     <= match_d;
      value_q     <= value_d;
      neg_q       <= neg_d;
      started_q   <= started_d;
      stopped_q   <= stopped_d;
      rx_check_q  <= rx_check_d;
      psum_q      <= psum_d;
      pcnt_q      <= pcnt_d;
      esum_q      <= esum_d;
      ecnt_q      <= ecnt_d;
    end
  end

  // average division and output register
  mlca_avg_pipe #(
    .SAMPLES_PER_AVERAGE(SAMPLES_PER_AVERAGE)
  ) u_avg_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .line_valid_i(line_valid),
    .line_ready_o(pipe_ready),
    .line_i      (line_d),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

@@ hw/rtl/mlca_checker.sv @@
// port-level checks for the meter line check and average unit, bound to the top level
module mlca_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input mlca_pkg::mlca_in_t  in_data_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input mlca_pkg::mlca_out_t out_data_o
);
  import mlca_pkg::*;

  // a held output transaction stays valid
  a_out_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output transaction dropped while stalled");

  // a held output transaction keeps its payload
  a_out_data_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("output payload changed while stalled");

  // input is held back only by a held output
  a_in_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

  // an average only comes with an accepted line
  a_avg_needs_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.average_valid |-> out_data_o.status == STATUS_OK)
    else $error("average reported on a rejected line");

  // without an average the average fields are zero
  a_no_avg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.average_valid |->
      !out_data_o.average_kind && out_data_o.average_value == '0)
    else $error("average fields set without an average");

endmodule

bind meter_line_check_and_average_unit mlca_checker u_mlca_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .in_data_i  (in_data_i),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_data_o (out_data_o)
);

@@ bench/meter_line_check_and_average_unit_checker.sv @@
// line report predictor and scoreboard for the meter line check and average unit
module meter_line_check_and_average_unit_checker #(
  parameter int unsigned SAMPLES_PER_AVERAGE = 60
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  mlca_pkg::mlca_in_t  in_data_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  mlca_pkg::mlca_out_t out_data_i,
  output int                  fail_count_o,
  output int                  pending_reports_o
);
  import mlca_pkg::*;

  // average kinds as carried in a report
  localparam logic KIND_POWER  = 1'b0;
  localparam logic KIND_ENERGY = 1'b1;

  // signed divisors for the truncating averages
  localparam longint SAMPLE_DIV = SAMPLES_PER_AVERAGE;
  localparam longint WH_PER_KWH = 1000;

  localparam int MAX_PRINTED = 100;

  // per-line parse state
  mlca_phase_e phase_q;
  logic [5:0]  check_sum_q;
  logic [2:0]  label_len_q;
  logic        is_papp_q;
  logic        is_base_q;
  logic [31:0] magnitude_q;
  logic        negative_q;
  logic        started_q;
  logic        stopped_q;
  logic [7:0]  check_byte_q;

  // accumulators that survive across lines
  logic [ACC_W-1:0] power_acc_q;
  logic [ACC_W-1:0] energy_acc_q;
  logic [CNT_W-1:0] power_cnt_q;
  logic [CNT_W-1:0] energy_cnt_q;

  // reports predicted but not yet seen on the output
  mlca_out_t line_reports_q [$];
  int        fail_count;

  assign fail_count_o = fail_count;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (fail_count < MAX_PRINTED) begin
      $display("%0t line report mismatch in %s: got %0h, predicted %0h",
               $time, what, got, want);
    end
    fail_count++;
  endtask

  function automatic void start_new_line();
    phase_q      = PH_LABEL;
    check_sum_q  = CHECK_SEED;
    label_len_q  = '0;
    is_papp_q    = 1'b1;
    is_base_q    = 1'b1;
    magnitude_q  = '0;
    negative_q   = 1'b0;
    started_q    = 1'b0;
    stopped_q    = 1'b0;
    check_byte_q = '0;
  endfunction

  // advance the line state by one byte, queue a report at end of line
  task automatic take_line_byte(input mlca_in_t item);
    logic [7:0]         b;
    logic               skip;
    logic [63:0]        grown;
    logic signed [63:0] sample;
    logic signed [39:0] acc;
    longint             quotient;
    mlca_out_t          rpt;
    b = item.line_byte;
    case (phase_q)
      PH_LABEL: begin
        if (b == CHAR_SPACE) begin
          phase_q = PH_VALUE;
        end else begin
          check_sum_q = check_sum_q + b[5:0];
          if (label_len_q < LABEL_LEN) begin
            if (b != WORD_PAPP[label_len_q[1:0]]) is_papp_q = 1'b0;
            if (b != WORD_BASE[label_len_q[1:0]]) is_base_q = 1'b0;
          end else begin
            is_papp_q = 1'b0;
            is_base_q = 1'b0;
          end
          if (label_len_q < LABEL_LEN_MAX) label_len_q = label_len_q + 1'b1;
        end
      end
      PH_VALUE: begin
        if (b == CHAR_SPACE) begin
          phase_q = PH_CHECK;
        end else begin
          check_sum_q = check_sum_q + b[5:0];
          // atoi: leading white space, one sign, digits until anything else
          skip = stopped_q || (!started_q && b >= CHAR_TAB && b <= CHAR_CR);
          if (!skip) begin
            if (!started_q && (b == CHAR_PLUS || b == CHAR_MINUS)) begin
              started_q  = 1'b1;
              negative_q = (b == CHAR_MINUS);
            end else if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
              grown = 64'(magnitude_q) * 64'd10 + 64'(b - CHAR_ZERO);
              magnitude_q = (grown > 64'(MAG_LIMIT)) ? MAG_LIMIT : grown[31:0];
              started_q = 1'b1;
            end else begin
              stopped_q = 1'b1;
            end
          end
        end
      end
      PH_CHECK: begin
        check_byte_q = b;
        phase_q = PH_DONE;
      end
      default: begin
        // bytes after the check character are ignored
      end
    endcase

    if (item.end_of_line) begin
      rpt = '0;
      if (phase_q == PH_LABEL) begin
        rpt.status = STATUS_NO_VALUE_SEP;
      end else if (phase_q == PH_VALUE) begin
        rpt.status = STATUS_NO_CHECK_SEP;
      end else if (phase_q == PH_CHECK ||
                   check_byte_q != ({2'b00, check_sum_q} + CHECK_OFFSET)) begin
        rpt.status = STATUS_BAD_CHECK;
      end else begin
        rpt.status = STATUS_OK;
      end

      // accepted papp or base line feeds its accumulator
      if (rpt.status == STATUS_OK && label_len_q == LABEL_LEN &&
          (is_papp_q || is_base_q)) begin
        sample = 64'(magnitude_q);
        if (negative_q) begin
          sample = -sample;
        end else if (magnitude_q > POS_LIMIT) begin
          sample = 64'(POS_LIMIT);
        end
        if (is_papp_q) begin
          power_acc_q = power_acc_q + sample[ACC_W-1:0];
          power_cnt_q = power_cnt_q + 1'b1;
          if (power_cnt_q == SAMPLES_PER_AVERAGE) begin
            acc = power_acc_q;
            quotient = longint'(acc) / SAMPLE_DIV;
            rpt.average_valid = 1'b1;
            rpt.average_kind  = KIND_POWER;
            rpt.average_value = quotient[31:0];
            power_acc_q = '0;
            power_cnt_q = '0;
          end
        end else begin
          energy_acc_q = energy_acc_q + sample[ACC_W-1:0];
          energy_cnt_q = energy_cnt_q + 1'b1;
          if (energy_cnt_q == SAMPLES_PER_AVERAGE) begin
            acc = energy_acc_q;
            quotient = (longint'(acc) / WH_PER_KWH) / SAMPLE_DIV;
            rpt.average_valid = 1'b1;
            rpt.average_kind  = KIND_ENERGY;
            rpt.average_value = quotient[31:0];
            energy_acc_q = '0;
            energy_cnt_q = '0;
          end
        end
      end
      line_reports_q.push_back(rpt);
      start_new_line();
    end
  endtask

  // watch both channels; output side first since a report never leaves
  // in the cycle its last byte is taken
  always @(posedge clk_i or negedge rst_ni) begin
    mlca_out_t want;
    if (!rst_ni) begin
      start_new_line();
      power_acc_q  = '0;
      energy_acc_q = '0;
      power_cnt_q  = '0;
      energy_cnt_q = '0;
      line_reports_q.delete();
      pending_reports_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (line_reports_q.size() == 0) begin
          report_mismatch("unrequested transaction", out_data_i[31:0], '0);
        end else begin
          want = line_reports_q.pop_front();
          if (out_data_i.status !== want.status) begin
            report_mismatch("status", out_data_i.status, want.status);
          end
          if (out_data_i.average_valid !== want.average_valid) begin
            report_mismatch("average_valid", out_data_i.average_valid,
                            want.average_valid);
          end
          if (out_data_i.average_kind !== want.average_kind) begin
            report_mismatch("average_kind", out_data_i.average_kind,
                            want.average_kind);
          end
          if (out_data_i.average_value !== want.average_value) begin
            report_mismatch("average_value", out_data_i.average_value,
                            want.average_value);
          end
        end
      end
      if (in_valid_i && !in_stall_i) take_line_byte(in_data_i);
      pending_reports_o <= line_reports_q.size();
    end
  end

endmodule

@@ bench/meter_line_check_and_average_unit_tb.sv @@
// testbench top: drives meter lines into the unit and gives the verdict
module meter_line_check_and_average_unit_tb;
  import mlca_pkg::*;

  localparam int unsigned SAMPLES      = 60;
  localparam int unsigned QUIET_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned PHASE_BYTES  = 300;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  mlca_in_t  in_data_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  mlca_out_t out_data_o;

  int          fail_count;
  int          pending_reports;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned quiet_cycles  = 0;
  logic [7:0]  line_buf [$];

  meter_line_check_and_average_unit #(
    .SAMPLES_PER_AVERAGE(SAMPLES)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  meter_line_check_and_average_unit_checker #(
    .SAMPLES_PER_AVERAGE(SAMPLES)
  ) line_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .in_data_i        (in_data_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_data_i       (out_data_o),
    .fail_count_o     (fail_count),
    .pending_reports_o(pending_reports)
  );

  always #1 clk_i = ~clk_i;

  // receiver side stalls at random
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("meter_line_check_and_average_unit_tb: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic eol);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{line_byte: b, end_of_line: eol};
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic send_line();
    foreach (line_buf[i]) send_byte(line_buf[i], i == line_buf.size() - 1);
  endtask

  // hold off the sender until every predicted report has come out
  task automatic drain_reports();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_reports != 0) @(posedge clk_i);
  endtask

  function automatic void add_text(ref logic [7:0] q [$], input string s);
    foreach (s[i]) q.push_back(s[i]);
  endfunction

  // label, space, value, space, check character
  task automatic compose_line(ref logic [7:0] label_q [$], ref logic [7:0] value_q [$],
                              input logic corrupt);
    logic [5:0] sum;
    logic [7:0] chk;
    sum = CHECK_SEED;
    foreach (label_q[i]) sum = sum + label_q[i][5:0];
    foreach (value_q[i]) sum = sum + value_q[i][5:0];
    chk = {2'b00, sum} + CHECK_OFFSET;
    if (corrupt) chk = chk ^ 8'($urandom_range(1, 255));
    line_buf = label_q;
    line_buf.push_back(CHAR_SPACE);
    foreach (value_q[i]) line_buf.push_back(value_q[i]);
    line_buf.push_back(CHAR_SPACE);
    line_buf.push_back(chk);
  endtask

  // meter line with random label choice and value text, check sometimes corrupted
  task automatic make_meter_line();
    logic [7:0]  label_q [$];
    logic [7:0]  value_q [$];
    logic [7:0]  junk;
    int unsigned digits;
    int unsigned pick;
    logic        check_ok;
    pick = $urandom_range(19);
    if (pick < 9) begin
      add_text(label_q, "PAPP");
    end else if (pick < 18) begin
      add_text(label_q, "BASE");
    end else begin
      case ($urandom_range(6))
        0: add_text(label_q, "IINST");
        1: add_text(label_q, "PAP");
        2: add_text(label_q, "BASEX");
        3: add_text(label_q, "PAPB");
        4: add_text(label_q, "PAPPPPPP");
        5: add_text(label_q, "HCHC");
        default: begin
          repeat ($urandom_range(1, 6)) begin
            junk = 8'($urandom_range(255));
            label_q.push_back((junk == CHAR_SPACE) ? (junk ^ 8'h01) : junk);
          end
        end
      endcase
    end

    // leading white space and sign
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(1, 2)) value_q.push_back(8'($urandom_range(CHAR_TAB, CHAR_CR)));
    end
    case ($urandom_range(7))
      0: value_q.push_back(CHAR_MINUS);
      1: value_q.push_back(CHAR_PLUS);
      default: begin
      end
    endcase

    // digits: mostly short, some long, some right at the saturation edge
    digits = 0;
    case ($urandom_range(15))
      0: begin
        add_text(value_q, "214748364");
        value_q.push_back(CHAR_ZERO + 8'($urandom_range(7, 9)));
      end
      1: digits = $urandom_range(10, 13);
      2: digits = 0;
      3, 4, 5, 6: digits = $urandom_range(6, 9);
      default: digits = $urandom_range(1, 4);
    endcase
    repeat (digits) value_q.push_back(CHAR_ZERO + 8'($urandom_range(9)));

    // stray character that stops the number, maybe digits after it
    if ($urandom_range(9) == 0) begin
      junk = 8'($urandom_range(255));
      value_q.push_back((junk == CHAR_SPACE) ? (junk ^ 8'h01) : junk);
      if ($urandom_range(1) == 0) value_q.push_back(CHAR_ZERO + 8'($urandom_range(9)));
    end

    check_ok = ($urandom_range(19) != 0);
    compose_line(label_q, value_q, !check_ok);

    // bytes after the check character
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(1, 3)) line_buf.push_back(8'($urandom_range(255)));
    end
  endtask

  task automatic run_random_phase();
    int unsigned bytes_sent;
    int unsigned roll;
    int unsigned cut;
    bytes_sent = 0;
    while (bytes_sent < PHASE_BYTES) begin
      roll = $urandom_range(99);
      if (roll < 7) begin
        // raw noise, spaces more likely than their fair share
        line_buf.delete();
        repeat ($urandom_range(1, 12)) begin
          line_buf.push_back(($urandom_range(3) == 0) ? CHAR_SPACE : 8'($urandom_range(255)));
        end
      end else begin
        make_meter_line();
        if (roll < 14) begin
          // line cut short somewhere
          cut = $urandom_range(1, line_buf.size());
          while (line_buf.size() > cut) void'(line_buf.pop_back());
        end
      end
      bytes_sent += line_buf.size();
      send_line();
      if ($urandom_range(39) == 0) drain_reports();
    end
  endtask

  initial begin
    logic [7:0] label_q [$];
    logic [7:0] value_q [$];
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 36;
    recv_idle_pct = 53;

    // top byte value alone: no separator at all
    line_buf = {8'hff};
    send_line();
    // zero byte label, line ends on the first space
    line_buf = {8'h00, CHAR_SPACE};
    send_line();
    // empty label and value, ends right after the second space
    line_buf = {CHAR_SPACE, CHAR_SPACE};
    send_line();
    // high byte label, overflowing value, zero as the check character
    line_buf = {8'h80, CHAR_SPACE};
    add_text(line_buf, "9999999999");
    line_buf.push_back(CHAR_SPACE);
    line_buf.push_back(8'h00);
    send_line();
    // accepted base line with a negative value
    add_text(label_q, "BASE");
    add_text(value_q, "-7");
    compose_line(label_q, value_q, 1'b0);
    send_line();

    run_random_phase();
    drain_reports();

    send_idle_pct = 53;
    recv_idle_pct = 36;
    run_random_phase();
    drain_reports();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random_phase();

    drain_reports();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("meter_line_check_and_average_unit_tb: clean");
    end else begin
      $display("meter_line_check_and_average_unit_tb: errors");
    end
    $finish;
  end

endmodule
